/* rtl/core/dqrl_pkg.sv */
package dqrl_pkg;

	// field and register widths
	localparam int BYTE_QUOTA_W = 40;
	localparam int OP_QUOTA_W   = 24;
	localparam int BYTES_LEFT_W = 42;
	localparam int OPS_LEFT_W   = 25;
	localparam int BYTES_W      = 32;
	localparam int APB_DATA_W   = 64;
	localparam int APB_ADDR_W   = 4;

	// item kinds
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// request operations
	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;
	localparam logic [1:0] OP_DELETE = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_GRANTED  = 2'd0;
	localparam logic [1:0] STATUS_RELEASED = 2'd1;
	localparam logic [1:0] STATUS_BUSY     = 2'd2;

	// register index, taken from paddr bit 3 (registers at 0x0 and 0x8)
	localparam logic REG_BYTE_QUOTA = 1'b0;
	localparam logic REG_OP_QUOTA   = 1'b1;

	typedef struct packed {
		logic [BYTE_QUOTA_W-1:0] byte_quota;
		logic [OP_QUOTA_W-1:0]   op_quota;
	} cfg_t;

	typedef struct packed {
		logic               emit;
		logic [1:0]         status;
		logic [BYTES_W-1:0] bytes;
	} result_t;

endpackage

/* rtl/core/dqrl_cfg_regs.sv */
module dqrl_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dqrl_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [dqrl_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [dqrl_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output dqrl_pkg::cfg_t                    cfg
);

	dqrl_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_quota <= '0;
			cfg_q.op_quota   <= '0;
		end else if (wr_en) begin
			case (paddr[3])
				dqrl_pkg::REG_BYTE_QUOTA: begin
					cfg_q.byte_quota <= pwdata[dqrl_pkg::BYTE_QUOTA_W-1:0];
				end
				dqrl_pkg::REG_OP_QUOTA: begin
					cfg_q.op_quota <= pwdata[dqrl_pkg::OP_QUOTA_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			dqrl_pkg::REG_BYTE_QUOTA: prdata = dqrl_pkg::APB_DATA_W'(cfg_q.byte_quota);
			dqrl_pkg::REG_OP_QUOTA:   prdata = dqrl_pkg::APB_DATA_W'(cfg_q.op_quota);
			default:                  prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/dqrl_core.sv */
module dqrl_core #(
	parameter int CNT_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 cmd,
	input  logic [1:0]           op_kind,
	input  logic [CNT_W-1:0]     count,
	input  dqrl_pkg::cfg_t       cfg,
	output dqrl_pkg::result_t    res
);

	localparam int BlW  = dqrl_pkg::BYTES_LEFT_W;
	localparam int OlW  = dqrl_pkg::OPS_LEFT_W;
	localparam int BlxW = BlW + 1;
	localparam int OlxW = OlW + 1;

	// remainders are two's complement, sign in the top bit
	logic [BlW-1:0]   bytes_left_q, bytes_left_d;
	logic [OlW-1:0]   ops_left_q, ops_left_d;
	logic             new_period_q, new_period_d;
	logic             held_q, held_d;
	logic [CNT_W-1:0] held_bytes_q;
	logic             held_bytes_we;

	logic             byte_en, op_en, overdrawn, pass_through;
	logic [BlxW-1:0]  bl_sub;
	logic [OlxW-1:0]  ol_sub;
	logic [BlW-1:0]   bl_charged, bl_fill;
	logic [OlW-1:0]   ol_charged, ol_fill;

	assign byte_en = (cfg.byte_quota != '0);
	assign op_en   = (cfg.op_quota != '0);

	// charge with saturation at the most negative value; only the sign matters once overdrawn
	always_comb begin
		bl_sub = {bytes_left_q[BlW-1], bytes_left_q} - BlxW'(count);
		ol_sub = {ops_left_q[OlW-1], ops_left_q} - OlxW'(1);
		if (!byte_en) begin
			bl_charged = bytes_left_q;
		end else if (bl_sub[BlxW-1] != bl_sub[BlxW-2]) begin
			bl_charged = {1'b1, {(BlW-1){1'b0}}};
		end else begin
			bl_charged = bl_sub[BlW-1:0];
		end
		if (!op_en) begin
			ol_charged = ops_left_q;
		end else if (ol_sub[OlxW-1] != ol_sub[OlxW-2]) begin
			ol_charged = {1'b1, {(OlW-1){1'b0}}};
		end else begin
			ol_charged = ol_sub[OlW-1:0];
		end
	end

	assign bl_fill = byte_en ? BlW'(cfg.byte_quota) : bytes_left_q;
	assign ol_fill = op_en ? OlW'(cfg.op_quota) : ops_left_q;

	assign overdrawn = (byte_en && bl_charged[BlW-1]) || (op_en && ol_charged[OlW-1]);
	assign pass_through = (!byte_en && !op_en)
		|| (op_kind == dqrl_pkg::OP_FLUSH) || (op_kind == dqrl_pkg::OP_DELETE);

	always_comb begin
		bytes_left_d  = bytes_left_q;
		ops_left_d    = ops_left_q;
		new_period_d  = new_period_q;
		held_d        = held_q;
		held_bytes_we = 1'b0;
		res.emit      = 1'b0;
		res.status    = dqrl_pkg::STATUS_GRANTED;
		res.bytes     = dqrl_pkg::BYTES_W'(count);
		if (step) begin
			if (cmd == dqrl_pkg::CMD_TICK) begin
				if (!held_q) begin
					new_period_d = 1'b1;
				end else begin
					bytes_left_d = bl_fill;
					ops_left_d   = ol_fill;
					new_period_d = 1'b0;
					held_d       = 1'b0;
					res.emit     = 1'b1;
					res.status   = dqrl_pkg::STATUS_RELEASED;
					res.bytes    = dqrl_pkg::BYTES_W'(held_bytes_q);
				end
			end else if (held_q) begin
				res.emit   = 1'b1;
				res.status = dqrl_pkg::STATUS_BUSY;
			end else if (pass_through) begin
				res.emit = 1'b1;
			end else if (overdrawn && new_period_q) begin
				bytes_left_d = bl_fill;
				ops_left_d   = ol_fill;
				new_period_d = 1'b0;
				res.emit     = 1'b1;
			end else if (overdrawn) begin
				bytes_left_d  = bl_charged;
				ops_left_d    = ol_charged;
				held_d        = 1'b1;
				held_bytes_we = 1'b1;
			end else begin
				bytes_left_d = bl_charged;
				ops_left_d   = ol_charged;
				res.emit     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			ops_left_q   <= '0;
			new_period_q <= 1'b1;
			held_q       <= 1'b0;
		end else begin
			bytes_left_q <= bytes_left_d;
			ops_left_q   <= ops_left_d;
			new_period_q <= new_period_d;
			held_q       <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (held_bytes_we) begin
			held_bytes_q <= count;
		end
	end

endmodule

/* rtl/core/dqrl_out_reg.sv */
module dqrl_out_reg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  dqrl_pkg::result_t                 res,
	output logic                              free,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [1:0]                        status,
	output logic [dqrl_pkg::BYTES_W-1:0]      granted_bytes
);

	logic                          valid_q;
	logic [1:0]                    status_q;
	logic [dqrl_pkg::BYTES_W-1:0]  bytes_q;

	assign free = !valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= step && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (free && step && res.emit) begin
			status_q <= res.status;
			bytes_q  <= res.bytes;
		end
	end

	assign res_valid     = valid_q;
	assign status        = status_q;
	assign granted_bytes = bytes_q;

endmodule

/* rtl/core/dual_quota_io_rate_limiter.sv */
// dual quota request gate
// requests (cmd 0) are charged against a byte quota and an operation quota,
// each enabled while its register is nonzero; ticks (cmd 1) open a new period
// input channel req_valid/req_ready carries cmd, op_kind, byte_count; the
// result channel res_valid/res_ready carries status and granted_bytes
// quotas are written over the apb port: byte quota at 0x0, op quota at 0x8
// an item is taken into an input register, worked in short logic (one
// subtract, a sign test and a reload per counter) and its result, if any,
// lands in the output register once that register is free; throughput is
// one item per clock while res_ready holds high; the counters update as
// each item is worked, so back to back items always see the latest remainders
// an overdrawn request in a period with no tick yet is held and produces no
// result until the next tick, which answers it with status released
// while res_valid is high and res_ready low the input register holds its item,
// so req_ready drops once it is full and stays low until the result is taken
// reset clears the quotas and remainders, marks a new period as seen and
// leaves no request held; no clearing pass is needed
module dual_quota_io_rate_limiter #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dqrl_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [dqrl_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [dqrl_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	// item input
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic                              cmd,
	input  logic [1:0]                        op_kind,
	input  logic [31:0]                       byte_count,
	// result output
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [1:0]                        status,
	output logic [31:0]                       granted_bytes
);

	// byte counts are taken modulo 2^COUNT_WIDTH, never wider than the port
	localparam int CntW = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

	dqrl_pkg::cfg_t    cfg;
	dqrl_pkg::result_t res;

	// input register
	logic             valid_s1;
	logic             cmd_s1;
	logic [1:0]       op_kind_s1;
	logic [CntW-1:0]  count_s1;

	logic out_free;
	logic step;

	// the stage advances whenever the output register can take a result
	assign step      = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1     <= cmd;
			op_kind_s1 <= op_kind;
			count_s1   <= byte_count[CntW-1:0];
		end
	end

	dqrl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// quota counters, period flag and held request
	dqrl_core #(
		.CNT_W (CntW)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.cmd     (cmd_s1),
		.op_kind (op_kind_s1),
		.count   (count_s1),
		.cfg     (cfg),
		.res     (res)
	);

	dqrl_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.res           (res),
		.free          (out_free),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.status        (status),
		.granted_bytes (granted_bytes)
	);

endmodule

/* rtl/core/dqrl_checker.sv */
module dqrl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [dqrl_pkg::APB_ADDR_W-1:0]   paddr,
	input logic [dqrl_pkg::APB_DATA_W-1:0]   pwdata,
	input logic [dqrl_pkg::APB_DATA_W-1:0]   prdata,
	input logic                              pready,
	input logic                              req_ready,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [1:0]                        status,
	input logic [31:0]                       granted_bytes
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(granted_bytes))
		else $error("result changed while stalled");

	// no unused status code ever leaves the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (status == dqrl_pkg::STATUS_GRANTED
			|| status == dqrl_pkg::STATUS_RELEASED || status == dqrl_pkg::STATUS_BUSY))
		else $error("bad status code");

	// with the output register empty the input side must not stall
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> req_ready)
		else $error("input stalled with empty output");

	// a written byte quota reads back on the next cycle
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(psel && penable && pwrite && pready)
		&& paddr[3] == $past(paddr[3]) && paddr[3] == dqrl_pkg::REG_BYTE_QUOTA
		|-> prdata[dqrl_pkg::BYTE_QUOTA_W-1:0] == $past(pwdata[dqrl_pkg::BYTE_QUOTA_W-1:0]))
		else $error("byte quota read-back mismatch");

endmodule

bind dual_quota_io_rate_limiter dqrl_checker u_dqrl_checker (.*);

/* bench/dual_quota_io_rate_limiter_tb.sv */
`timescale 1ns / 1ps

module dual_quota_io_rate_limiter_tb;

	// run limits
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_WAIT  = 4;

	// one storage request or period tick
	typedef struct {
		logic                         kind;
		logic [1:0]                   op;
		logic [dqrl_pkg::BYTES_W-1:0] bytes;
	} io_item_t;

	// one answer from the gate
	typedef struct {
		logic [1:0]                   status;
		logic [dqrl_pkg::BYTES_W-1:0] bytes;
	} grant_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              psel = 1'b0;
	logic                              penable = 1'b0;
	logic                              pwrite = 1'b0;
	logic [dqrl_pkg::APB_ADDR_W-1:0]   paddr = '0;
	logic [dqrl_pkg::APB_DATA_W-1:0]   pwdata = '0;
	logic [dqrl_pkg::APB_DATA_W-1:0]   prdata;
	logic                              pready;
	logic                              req_valid = 1'b0;
	logic                              req_ready;
	logic                              cmd = dqrl_pkg::CMD_REQUEST;
	logic [1:0]                        op_kind = dqrl_pkg::OP_READ;
	logic [31:0]                       byte_count = '0;
	logic                              res_valid;
	logic                              res_ready = 1'b0;
	logic [1:0]                        status;
	logic [31:0]                       granted_bytes;

	// stimulus and scoreboard
	io_item_t pending_items[$];
	grant_t   grant_expected[$];
	grant_t   next_grant;
	io_item_t next_item;
	int       items_queued = 0;
	int       items_taken = 0;
	int       results_taken = 0;
	int       fail_count = 0;
	int       cycle_count = 0;

	// sender and receiver idling
	int       send_gap = 0;
	int       recv_hold = 0;
	bit       sender_calm = 1'b0;
	bit       receiver_calm = 1'b0;

	// our own copy of the gate: quota registers and period state
	logic [dqrl_pkg::BYTE_QUOTA_W-1:0] byte_quota = '0;
	logic [dqrl_pkg::OP_QUOTA_W-1:0]   op_quota = '0;
	longint                            bytes_remaining = 0;
	longint                            ops_remaining = 0;
	bit                                period_open = 1'b1;
	bit                                req_parked = 1'b0;
	logic [dqrl_pkg::BYTES_W-1:0]      parked_bytes = '0;

	dual_quota_io_rate_limiter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.cmd           (cmd),
		.op_kind       (op_kind),
		.byte_count    (byte_count),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.status        (status),
		.granted_bytes (granted_bytes)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// gate prediction
	// ---------------------------------------------------------------

	function automatic void note_grant(input logic [1:0] st,
			input logic [dqrl_pkg::BYTES_W-1:0] b);
		grant_t g;
		g.status = st;
		g.bytes  = b;
		grant_expected.push_back(g);
	endfunction

	// a refill forgives any overdraft, but only on the enabled quotas
	function automatic void refill_quotas();
		if (byte_quota != 0) bytes_remaining = longint'(byte_quota);
		if (op_quota != 0) ops_remaining = longint'(op_quota);
	endfunction

	function automatic void gate_predict(input logic kind, input logic [1:0] op,
			input logic [dqrl_pkg::BYTES_W-1:0] b);
		bit overdraw;
		if (kind == dqrl_pkg::CMD_TICK) begin
			if (!req_parked) begin
				// nothing waiting: the tick only opens a new period
				period_open = 1'b1;
			end else begin
				// the parked request goes out with the refill
				refill_quotas();
				period_open = 1'b0;
				req_parked  = 1'b0;
				note_grant(dqrl_pkg::STATUS_RELEASED, parked_bytes);
			end
		end else if (req_parked) begin
			// anything arriving behind a parked request is turned away
			note_grant(dqrl_pkg::STATUS_BUSY, b);
		end else if ((byte_quota == 0 && op_quota == 0) || op == dqrl_pkg::OP_FLUSH
				|| op == dqrl_pkg::OP_DELETE) begin
			note_grant(dqrl_pkg::STATUS_GRANTED, b);
		end else begin
			if (byte_quota != 0) bytes_remaining = bytes_remaining - longint'(b);
			if (op_quota != 0) ops_remaining = ops_remaining - 1;
			overdraw = (byte_quota != 0 && bytes_remaining < 0) ||
				(op_quota != 0 && ops_remaining < 0);
			if (overdraw && !period_open) begin
				// no tick since the last refill: park it, no answer yet
				req_parked   = 1'b1;
				parked_bytes = b;
			end else begin
				if (overdraw) begin
					refill_quotas();
					period_open = 1'b0;
				end
				note_grant(dqrl_pkg::STATUS_GRANTED, b);
			end
		end
	endfunction

	// ---------------------------------------------------------------
	// item sender: valid held with a steady payload until taken
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				gate_predict(cmd, op_kind, byte_count);
				items_taken++;
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0 || pending_items.size() == 0) begin
					if (send_gap > 0) send_gap--;
					req_valid <= 1'b0;
				end else begin
					next_item = pending_items.pop_front();
					req_valid  <= 1'b1;
					cmd        <= next_item.kind;
					op_kind    <= next_item.op;
					byte_count <= next_item.bytes;
					// now and then swap between gappy and back to back
					if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
					send_gap = sender_calm ? 0 : $urandom_range(0, 5);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result receiver and checker
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				results_taken++;
				if (grant_expected.size() == 0) begin
					$error("unexpected result: status %0d granted_bytes %0d",
						status, granted_bytes);
					fail_count++;
				end else begin
					next_grant = grant_expected.pop_front();
					if (status !== next_grant.status) begin
						$error("status: expected %0d, actual %0d", next_grant.status, status);
						fail_count++;
					end
					if (granted_bytes !== next_grant.bytes) begin
						$error("granted_bytes: expected %0d, actual %0d",
							next_grant.bytes, granted_bytes);
						fail_count++;
					end
				end
				// a long hold-off now and then so the gate backs up onto its input
				if (results_taken == 60 || results_taken == 400) begin
					recv_hold = LONG_HOLD;
				end else begin
					if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
					recv_hold = receiver_calm ? 0 : $urandom_range(0, 5);
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	function automatic void offer(input logic kind, input logic [1:0] op,
			input logic [dqrl_pkg::BYTES_W-1:0] b);
		io_item_t it;
		it.kind  = kind;
		it.op    = op;
		it.bytes = b;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	// wait until every item is in and answered, then let the pipe drain
	task automatic settle();
		do @(posedge clk);
		while (items_taken != items_queued || grant_expected.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// setup then access phase; psel stays up across a back to back pair
	task automatic write_quota(input logic reg_sel,
			input logic [dqrl_pkg::APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (reg_sel == dqrl_pkg::REG_BYTE_QUOTA) byte_quota = value[dqrl_pkg::BYTE_QUOTA_W-1:0];
		else op_quota = value[dqrl_pkg::OP_QUOTA_W-1:0];
	endtask

	task automatic set_quotas(input logic [dqrl_pkg::APB_DATA_W-1:0] bq,
			input logic [dqrl_pkg::APB_DATA_W-1:0] oq);
		write_quota(dqrl_pkg::REG_BYTE_QUOTA, bq);
		write_quota(dqrl_pkg::REG_OP_QUOTA, oq);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mostly reads and writes sized around the byte quota, some ticks,
	// flushes, deletes and extreme counts; a closing tick frees any parked request
	task automatic offer_random(input int n);
		logic [1:0]                   op;
		logic [dqrl_pkg::BYTES_W-1:0] b;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: b = $urandom;
				1: b = '0;
				2: b = '1;
				default: begin
					if (byte_quota == 0) b = $urandom_range(0, 4095);
					else if (byte_quota > 40'hFF_FFFF_FFFF >> 8) b = $urandom;
					else b = $urandom_range(0, byte_quota[31:0] / 2 + 1);
				end
			endcase
			if ($urandom_range(0, 4) == 0) begin
				op = 2'($urandom_range(dqrl_pkg::OP_FLUSH, dqrl_pkg::OP_DELETE));
			end else begin
				op = 2'($urandom_range(dqrl_pkg::OP_READ, dqrl_pkg::OP_WRITE));
			end
			if ($urandom_range(0, 5) == 0) offer(dqrl_pkg::CMD_TICK, op, b);
			else offer(dqrl_pkg::CMD_REQUEST, op, b);
		end
		offer(dqrl_pkg::CMD_TICK, dqrl_pkg::OP_READ, '0);
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// both quotas off after reset: everything passes, a lone tick says nothing
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_READ, '0);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_WRITE, 32'hFFFF_FFFF);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_FLUSH, 32'h5555_5555);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_DELETE, 32'hAAAA_AAAA);
		offer(dqrl_pkg::CMD_TICK, dqrl_pkg::OP_READ, '0);
		settle();

		// small quotas: refill on overdraft with a fresh period, park without one
		set_quotas(64'd100, 64'd2);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_READ, 32'd60);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_WRITE, 32'd60);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_READ, 32'd200);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_WRITE, 32'd5);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_FLUSH, 32'd7);
		offer(dqrl_pkg::CMD_TICK, dqrl_pkg::OP_READ, '0);
		offer(dqrl_pkg::CMD_TICK, dqrl_pkg::OP_READ, '0);
		// operation quota runs out first
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_READ, '0);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_READ, '0);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_READ, '0);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_WRITE, '0);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_WRITE, '0);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_DELETE, 32'd9);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_READ, '0);
		offer(dqrl_pkg::CMD_REQUEST, dqrl_pkg::OP_DELETE, 32'd3);
		offer(dqrl_pkg::CMD_TICK, dqrl_pkg::OP_READ, '0);
		offer(dqrl_pkg::CMD_TICK, dqrl_pkg::OP_READ, '0);
		settle();

		// byte limit alone
		set_quotas(64'd5000, 64'd0);
		offer_random(170);
		settle();

		// operation limit alone; bits above the register are dropped
		set_quotas(64'd0, 64'hFFFF_FFFF_FF00_0003);
		offer_random(170);
		settle();

		// both at their largest
		set_quotas(64'h00FF_FFFF_FFFF, 64'h00FF_FFFF);
		offer_random(100);
		settle();

		// both at their smallest enabled value
		set_quotas(64'd1, 64'd1);
		offer_random(170);
		settle();

		// both enabled, moderate
		set_quotas(64'd20000, 64'd5);
		offer_random(170);
		settle();

		// back to unlimited
		set_quotas(64'd0, 64'd0);
		offer_random(140);
		settle();

		repeat (10) @(posedge clk);
		if (fail_count == 0 && grant_expected.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
